/* rtl/ihm_pkg.sv */
// Package for the insertion-ordered hash map core.
// Sizes, command codes and FSM state type; used by ihm_cfg and the top level.
package ihm_pkg;

  localparam int SLOT_BITS   = 8;
  localparam int SLOT_COUNT  = 1 << SLOT_BITS;
  localparam int MAX_ENTRIES = (SLOT_COUNT > 2) ? SLOT_COUNT - SLOT_COUNT / 4 : SLOT_COUNT - 1;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int PCNT_W      = SLOT_BITS + 1;
  localparam int POS_W       = (CNT_W > 8) ? CNT_W : 8;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int HASH_W  = 32;
  localparam int ENTRY_W = KEY_W + HASH_W + VAL_W;

  localparam logic [1:0] CMD_GET  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] ADDR_REPORT_FREED = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOT,
    ST_ENT,
    ST_CMP,
    ST_RD_WAIT,
    ST_SH_RD,
    ST_SH_WR,
    ST_RB_RD,
    ST_RB_HOME,
    ST_RB_SRCH,
    ST_RESP
  } state_e;

endpackage

/* rtl/ihm_ram.sv */
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module ihm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ihm_cfg.sv */
// APB-style register port holding report_freed.
// Depends on ihm_pkg.
module ihm_cfg
  import ihm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        report_freed_o
);

  logic report_q, report_d;

  assign pready = 1'b1;

  always_comb begin
    report_d = report_q;
    if (psel && penable && pwrite && paddr[2] == ADDR_REPORT_FREED[2]) begin
      report_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q <= 1'b0;
    end else begin
      report_q <= report_d;
    end
  end

  assign prdata = (paddr[2] == ADDR_REPORT_FREED[2]) ? {31'd0, report_q} : 32'd0;
  assign report_freed_o = report_q;

endmodule

/* rtl/insertion_ordered_hash_map_core.sv */
// Top level of the insertion-ordered hash map: command FSM, slot RAM, entry RAM.
// Depends on ihm_pkg, ihm_ram, ihm_cfg.
//
//  channel | handshake               | beat
//  in      | in_valid_i / in_stall_o | command, key, key_hash, value, position
//  out     | out_valid_o / out_stall_i | status, found, value_out, entry_key, freed_*, count
//  cfg     | psel/penable/pwrite     | report_freed at address 0
//
// One item at a time. Get and set probe linearly from the home slot: each occupied
// slot is read from the slot RAM, its entry read from the entry RAM and compared;
// the probe ends on a hit, an empty slot or after every slot. Read fetches one entry.
// A delete shifts every later entry down one place, then rebuilds the slot table by
// re-inserting each live entry at the first empty slot from its home slot. Reset
// empties the slot table at once (slot valid bits in flops). A stalled result holds in the output register.
module insertion_ordered_hash_map_core
  import ihm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_i,
  input  logic [31:0] key_hash_i,
  input  logic [63:0] value_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        found_o,
  output logic [63:0] value_out_o,
  output logic [63:0] entry_key_o,
  output logic        freed_valid_o,
  output logic [63:0] freed_value_o,
  output logic [7:0]  entry_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic report_freed;

  ihm_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .report_freed_o(report_freed)
  );

  state_e state_q, state_d;

  logic [1:0]            cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic [HASH_W-1:0]     hash_q;
  logic [VAL_W-1:0]      val_q;
  logic [7:0]            pos_q;
  logic [SLOT_BITS-1:0]  s_q, s_d;
  logic [PCNT_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]      e_q, e_d;
  logic [CNT_W-1:0]      i_q, i_d;
  logic [CNT_W-1:0]      live_q, live_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;

  logic             res_status_q, res_status_d;
  logic             res_found_q, res_found_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  logic [KEY_W-1:0] res_key_q, res_key_d;
  logic             res_fvalid_q, res_fvalid_d;
  logic [VAL_W-1:0] res_fvalue_q, res_fvalue_d;

  logic        out_valid_q;
  logic        out_status_q, out_found_q, out_fvalid_q;
  logic [63:0] out_value_q, out_key_q, out_fvalue_q;
  logic [7:0]  out_count_q;

  logic                 slot_we, slot_re;
  logic [SLOT_BITS-1:0] slot_addr;
  logic [IDX_W-1:0]     slot_wdata, slot_rdata;
  logic                 ent_we, ent_re;
  logic [IDX_W-1:0]     ent_addr;
  logic [ENTRY_W-1:0]   ent_wdata, ent_rdata;

  ihm_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk_i, .we_i(slot_we), .re_i(slot_re), .addr_i(slot_addr),
    .wdata_i(slot_wdata), .rdata_o(slot_rdata)
  );

  ihm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk_i, .we_i(ent_we), .re_i(ent_re), .addr_i(ent_addr),
    .wdata_i(ent_wdata), .rdata_o(ent_rdata)
  );

  // entry layout: {key, hash, value}
  logic [KEY_W-1:0]  ent_key;
  logic [HASH_W-1:0] ent_hash;
  logic [VAL_W-1:0]  ent_val;
  assign ent_key  = ent_rdata[ENTRY_W-1 -: KEY_W];
  assign ent_hash = ent_rdata[VAL_W +: HASH_W];
  assign ent_val  = ent_rdata[VAL_W-1:0];

  logic accept, out_free, slot_empty, hit, wrap, full, pos_ok;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign slot_empty = !valid_q[s_q];
  assign hit        = (CNT_W'(e_q) < live_q) && (ent_hash == hash_q) && (ent_key == key_q);
  assign wrap       = (n_q == PCNT_W'(SLOT_COUNT - 1));
  assign full       = (live_q >= CNT_W'(MAX_ENTRIES));
  assign pos_ok     = (POS_W'(pos_q) < POS_W'(live_q));
  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_GET || command_i == CMD_SET) state_d = ST_SLOT;
          else if (command_i == CMD_READ) state_d = ST_RD_WAIT;
          else state_d = ST_RESP;
        end
      end
      ST_SLOT:    state_d = slot_empty ? ST_RESP : ST_ENT;
      ST_ENT:     state_d = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_d = (cmd_q == CMD_SET && val_q == '0) ? ST_SH_RD : ST_RESP;
        end else begin
          state_d = wrap ? ST_RESP : ST_SLOT;
        end
      end
      ST_RD_WAIT: state_d = ST_RESP;
      ST_SH_RD:   state_d = (i_q < live_q) ? ST_SH_WR : ST_RB_RD;
      ST_SH_WR:   state_d = ST_SH_RD;
      ST_RB_RD:   state_d = (i_q < live_q) ? ST_RB_HOME : ST_RESP;
      ST_RB_HOME: state_d = ST_RB_SRCH;
      ST_RB_SRCH: state_d = slot_empty ? ST_RB_RD : ST_RB_SRCH;
      ST_RESP:    state_d = out_free ? ST_IDLE : ST_RESP;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    s_d = s_q; n_d = n_q; e_d = e_q; i_d = i_q; live_d = live_q; valid_d = valid_q;
    res_status_d = res_status_q; res_found_d = res_found_q; res_value_d = res_value_q;
    res_key_d = res_key_q; res_fvalid_d = res_fvalid_q; res_fvalue_d = res_fvalue_q;
    slot_we = 1'b0; slot_re = 1'b0; slot_addr = s_q; slot_wdata = IDX_W'(live_q);
    ent_we = 1'b0; ent_re = 1'b0; ent_addr = e_q; ent_wdata = ent_rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          s_d = key_hash_i[SLOT_BITS-1:0];
          n_d = '0;
          res_status_d = 1'b0; res_found_d = 1'b0; res_value_d = '0;
          res_key_d = '0; res_fvalid_d = 1'b0; res_fvalue_d = '0;
          if (command_i == CMD_READ) begin
            ent_re   = 1'b1;
            ent_addr = IDX_W'(position_i);
          end
        end
      end
      ST_SLOT: begin
        slot_re = !slot_empty;
        // probe ended on an empty slot: a new key goes right here unless the table is full
        if (slot_empty && cmd_q == CMD_SET && val_q != '0) begin
          if (full) begin
            res_status_d = 1'b1;
          end else begin
            ent_we     = 1'b1;
            ent_addr   = IDX_W'(live_q);
            ent_wdata  = {key_q, hash_q, val_q};
            slot_we    = 1'b1;
            valid_d[s_q] = 1'b1;
            live_d     = live_q + 1'b1;
          end
        end
      end
      ST_ENT: begin
        ent_re   = 1'b1;
        ent_addr = slot_rdata;
        e_d      = slot_rdata;
      end
      ST_CMP: begin
        if (hit) begin
          res_found_d = 1'b1;
          if (cmd_q == CMD_GET) begin
            res_value_d = ent_val;
          end else begin
            res_fvalid_d = report_freed;
            res_fvalue_d = report_freed ? ent_val : '0;
            if (val_q == '0) begin
              live_d  = live_q - 1'b1;
              i_d     = CNT_W'(e_q);
              valid_d = '0;
            end else begin
              ent_we    = 1'b1;
              ent_addr  = e_q;
              ent_wdata = {ent_key, ent_hash, val_q};
            end
          end
        end else begin
          s_d = s_q + 1'b1;
          n_d = n_q + 1'b1;
        end
      end
      ST_RD_WAIT: begin
        if (pos_ok) begin
          res_found_d = 1'b1;
          res_value_d = ent_val;
          res_key_d   = ent_key;
        end
      end
      ST_SH_RD: begin
        if (i_q < live_q) begin
          ent_re   = 1'b1;
          ent_addr = IDX_W'(i_q + 1'b1);
        end else begin
          i_d = '0;
        end
      end
      ST_SH_WR: begin
        ent_we    = 1'b1;
        ent_addr  = IDX_W'(i_q);
        ent_wdata = ent_rdata;
        i_d       = i_q + 1'b1;
      end
      ST_RB_RD: begin
        if (i_q < live_q) begin
          ent_re   = 1'b1;
          ent_addr = IDX_W'(i_q);
        end
      end
      ST_RB_HOME: begin
        s_d = ent_hash[SLOT_BITS-1:0];
      end
      ST_RB_SRCH: begin
        if (slot_empty) begin
          slot_we      = 1'b1;
          slot_wdata   = IDX_W'(i_q);
          valid_d[s_q] = 1'b1;
          i_d          = i_q + 1'b1;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      valid_q <= valid_d;
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      key_q  <= key_i;
      hash_q <= key_hash_i;
      val_q  <= value_i;
      pos_q  <= position_i;
    end
    s_q <= s_d; n_q <= n_d; e_q <= e_d; i_q <= i_d;
    res_status_q <= res_status_d; res_found_q <= res_found_d;
    res_value_q  <= res_value_d;  res_key_q   <= res_key_d;
    res_fvalid_q <= res_fvalid_d; res_fvalue_q <= res_fvalue_d;
    if (state_q == ST_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_value_q  <= res_value_q;
      out_key_q    <= res_key_q;
      out_fvalid_q <= res_fvalid_q;
      out_fvalue_q <= res_fvalue_q;
      out_count_q  <= 8'(live_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign value_out_o   = out_value_q;
  assign entry_key_o   = out_key_q;
  assign freed_valid_o = out_fvalid_q;
  assign freed_value_o = out_fvalue_q;
  assign entry_count_o = out_count_q;

endmodule
